/* hdl/pscb_pkg.sv */
package pscb_pkg;

  // Defaults for the top-level parameters
  localparam int SERVICE_COUNT_DEF = 64;
  localparam int TIME_BITS_DEF     = 32;

  // Fixed field widths
  localparam int SVC_W   = 6;
  localparam int TICK_W  = 32;
  localparam int LIMIT_W = 8;
  localparam int CNT_W   = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_CHECK   = 2'd0,
    MODE_FAIL    = 2'd1,
    MODE_SUCCESS = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    BRK_CLOSED = 2'd0,
    BRK_OPEN   = 2'd1,
    BRK_HALF   = 2'd2
  } brk_state_t;

  typedef enum logic [1:0] {
    CFG_FAIL_LIMIT    = 2'd0,
    CFG_SUCCESS_LIMIT = 2'd1,
    CFG_OPEN_TIME     = 2'd2
  } cfg_reg_t;

  // Register file contents as seen by the back end
  typedef struct packed {
    logic [LIMIT_W-1:0] fail_limit;
    logic [LIMIT_W-1:0] success_limit;
    logic [TICK_W-1:0]  open_time_limit;
  } cfg_t;

  // Classification of one queued beat
  typedef struct packed {
    mode_t mode;
    logic  in_range;
  } item_ctl_t;

  localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST    = 8'd4;
  localparam logic [LIMIT_W-1:0] SUCCESS_LIMIT_RST = 8'd2;
  localparam logic [TICK_W-1:0]  OPEN_TIME_RST     = 32'd1000000;

  // Saturating counter step
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : CNT_W'(c + 1'b1);
  endfunction

endpackage

/* hdl/per_service_circuit_breaker.sv */
// An accepted beat passes the queue, the execute stage and the output register.
// Throughput: one beat per cycle while out_stall is low; same-service beats
// in a row bypass the registered table read, so the one write port sets the rate.
// Reset: synchronous, active low; then a clearing pass wipes every table entry,
// in_stall is high meanwhile and config writes are still taken.
module per_service_circuit_breaker #(
  parameter int SERVICE_COUNT = pscb_pkg::SERVICE_COUNT_DEF,
  parameter int TIME_BITS     = pscb_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [pscb_pkg::SVC_W-1:0]    in_service_index,
  input  logic [pscb_pkg::TICK_W-1:0]   in_now_ticks,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_allowed,
  output logic [1:0]                    out_breaker_after,
  output logic                          out_known,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [pscb_pkg::TICK_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(SERVICE_COUNT);

  pscb_pkg::cfg_t       cfg_r;
  logic                 clr_busy;
  logic                 deq;
  logic                 q_valid;
  pscb_pkg::item_ctl_t  q_ctl;
  logic [IDX_W-1:0]     q_idx;
  logic [TIME_BITS-1:0] q_now;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fail_limit      <= pscb_pkg::FAIL_LIMIT_RST;
      cfg_r.success_limit   <= pscb_pkg::SUCCESS_LIMIT_RST;
      cfg_r.open_time_limit <= pscb_pkg::OPEN_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pscb_pkg::cfg_reg_t'(cfg_index))
        pscb_pkg::CFG_FAIL_LIMIT:    cfg_r.fail_limit      <= cfg_data[pscb_pkg::LIMIT_W-1:0];
        pscb_pkg::CFG_SUCCESS_LIMIT: cfg_r.success_limit   <= cfg_data[pscb_pkg::LIMIT_W-1:0];
        pscb_pkg::CFG_OPEN_TIME:     cfg_r.open_time_limit <= cfg_data;
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  pscb_front #(
    .SERVICE_COUNT (SERVICE_COUNT),
    .TIME_BITS     (TIME_BITS),
    .IDX_W         (IDX_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_service_index (in_service_index),
    .in_now_ticks     (in_now_ticks),
    .busy             (clr_busy),
    .deq              (deq),
    .q_valid          (q_valid),
    .q_ctl            (q_ctl),
    .q_idx            (q_idx),
    .q_now            (q_now)
  );

  pscb_back #(
    .SERVICE_COUNT (SERVICE_COUNT),
    .TIME_BITS     (TIME_BITS),
    .IDX_W         (IDX_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_ctl             (q_ctl),
    .q_idx             (q_idx),
    .q_now             (q_now),
    .deq               (deq),
    .busy              (clr_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_allowed       (out_allowed),
    .out_breaker_after (out_breaker_after),
    .out_known         (out_known)
  );

  // No beat enters while the table is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> in_stall)
    else $error("beat accepted during clearing pass");

  // The back end only pops a non-empty queue
  a_deq_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    deq |-> q_valid)
    else $error("pop from empty queue");

  // An allowed check never leaves the breaker open
  a_allowed_not_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_allowed) |-> (out_breaker_after != pscb_pkg::BRK_OPEN))
    else $error("allowed beat reports open breaker");

  // A service without an entry reports closed
  a_unknown_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_known) |-> (out_breaker_after == pscb_pkg::BRK_CLOSED))
    else $error("unknown service reports non-closed state");

endmodule

/* hdl/pscb_ram.sv */
module pscb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read returns old data on collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/pscb_front.sv */
module pscb_front #(
  parameter int SERVICE_COUNT = pscb_pkg::SERVICE_COUNT_DEF,
  parameter int TIME_BITS     = pscb_pkg::TIME_BITS_DEF,
  parameter int IDX_W         = $clog2(SERVICE_COUNT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [pscb_pkg::SVC_W-1:0]    in_service_index,
  input  logic [pscb_pkg::TICK_W-1:0]   in_now_ticks,
  // back end
  input  logic                          busy,
  input  logic                          deq,
  output logic                          q_valid,
  output pscb_pkg::item_ctl_t           q_ctl,
  output logic [IDX_W-1:0]              q_idx,
  output logic [TIME_BITS-1:0]          q_now
);

  localparam int QD    = pscb_pkg::QUEUE_DEPTH;
  localparam int QP_W  = (QD > 1) ? $clog2(QD) : 1;
  localparam int QC_W  = $clog2(QD + 1);
  localparam int EXT_W = (IDX_W > pscb_pkg::SVC_W) ? IDX_W : pscb_pkg::SVC_W;

  pscb_pkg::item_ctl_t  ctl_q_r [QD];
  logic [IDX_W-1:0]     idx_q_r [QD];
  logic [TIME_BITS-1:0] now_q_r [QD];
  logic [QP_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]      count_r;

  pscb_pkg::item_ctl_t  cls_ctl;
  logic [EXT_W-1:0]     svc_ext;
  logic                 push;

  // Classify the incoming beat
  always_comb begin
    svc_ext          = EXT_W'(in_service_index);
    cls_ctl.mode     = pscb_pkg::mode_t'(in_mode);
    cls_ctl.in_range = (32'(in_service_index) < 32'(SERVICE_COUNT));
  end

  assign in_stall = busy || (count_r == QC_W'(QD));
  assign push     = in_valid && !in_stall;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q_r[wr_ptr_r] <= cls_ctl;
      idx_q_r[wr_ptr_r] <= svc_ext[IDX_W-1:0];
      now_q_r[wr_ptr_r] <= TIME_BITS'(in_now_ticks);
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(QD - 1)) ? '0 : QP_W'(wr_ptr_r + 1'b1);
      end
      if (deq) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(QD - 1)) ? '0 : QP_W'(rd_ptr_r + 1'b1);
      end
      if (push && !deq) begin
        count_r <= QC_W'(count_r + 1'b1);
      end else if (!push && deq) begin
        count_r <= QC_W'(count_r - 1'b1);
      end
    end
  end

  assign q_valid = (count_r != '0);
  assign q_ctl   = ctl_q_r[rd_ptr_r];
  assign q_idx   = idx_q_r[rd_ptr_r];
  assign q_now   = now_q_r[rd_ptr_r];

endmodule

/* hdl/pscb_back.sv */
module pscb_back #(
  parameter int SERVICE_COUNT = pscb_pkg::SERVICE_COUNT_DEF,
  parameter int TIME_BITS     = pscb_pkg::TIME_BITS_DEF,
  parameter int IDX_W         = $clog2(SERVICE_COUNT)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pscb_pkg::cfg_t       cfg,
  // queue head
  input  logic                 q_valid,
  input  pscb_pkg::item_ctl_t  q_ctl,
  input  logic [IDX_W-1:0]     q_idx,
  input  logic [TIME_BITS-1:0] q_now,
  output logic                 deq,
  output logic                 busy,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_allowed,
  output logic [1:0]           out_breaker_after,
  output logic                 out_known
);

  localparam int CNT_W = pscb_pkg::CNT_W;
  localparam int CMP_W = (TIME_BITS > pscb_pkg::TICK_W) ? TIME_BITS : pscb_pkg::TICK_W;

  typedef struct packed {
    logic                    valid;
    pscb_pkg::brk_state_t    st;
    logic [CNT_W-1:0]        fcnt;
    logic [CNT_W-1:0]        scnt;
    logic [TIME_BITS-1:0]    stamp;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // clearing pass
  logic                 clr_active_r;
  logic [IDX_W-1:0]     clr_addr_r;

  // execute stage
  logic                 s1_valid_r;
  pscb_pkg::item_ctl_t  s1_ctl_r;
  logic [IDX_W-1:0]     s1_idx_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 fwd_r;
  ent_t                 fwd_ent_r;

  // output register
  logic                 out_valid_r;
  logic                 out_allowed_r;
  logic [1:0]           out_after_r;
  logic                 out_known_r;

  logic                 out_free, s1_done, s1_load;
  logic [ENT_W-1:0]     ram_rdata;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;

  ent_t                 cur_ent, new_ent;
  logic                 wr_need, res_allowed, res_known;
  pscb_pkg::brk_state_t res_after;
  logic [TIME_BITS-1:0] elapsed;
  logic [CNT_W-1:0]     f_inc, s_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_done  = s1_valid_r && out_free;
  assign s1_load  = q_valid && !clr_active_r && (!s1_valid_r || out_free);
  assign deq      = s1_load;
  assign busy     = clr_active_r;

  // Breaker table
  pscb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SERVICE_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (s1_load),
    .rd_addr (q_idx),
    .rd_data (ram_rdata)
  );

  // Write port: clearing pass first, then table updates
  always_comb begin
    if (clr_active_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_done && wr_need;
      ram_waddr = s1_idx_r;
      ram_wdata = new_ent;
    end
  end

  // Breaker update for the beat in the execute stage
  always_comb begin
    cur_ent     = fwd_r ? fwd_ent_r : ent_t'(ram_rdata);
    new_ent     = cur_ent;
    wr_need     = 1'b0;
    res_allowed = 1'b0;
    res_known   = s1_ctl_r.in_range && cur_ent.valid;
    elapsed     = s1_now_r - cur_ent.stamp;
    f_inc       = pscb_pkg::sat_inc(cur_ent.fcnt);
    s_inc       = pscb_pkg::sat_inc(cur_ent.scnt);

    if (res_known) begin
      wr_need = 1'b1;
      unique case (s1_ctl_r.mode)
        pscb_pkg::MODE_CHECK: begin
          if (cur_ent.st == pscb_pkg::BRK_OPEN) begin
            if (CMP_W'(elapsed) >= CMP_W'(cfg.open_time_limit)) begin
              new_ent.st   = pscb_pkg::BRK_HALF;
              new_ent.fcnt = '0;
              new_ent.scnt = '0;
              res_allowed  = 1'b1;
            end
          end else begin
            res_allowed = 1'b1;
          end
        end
        pscb_pkg::MODE_FAIL: begin
          unique case (cur_ent.st)
            pscb_pkg::BRK_HALF: begin
              new_ent.scnt  = '0;
              new_ent.st    = pscb_pkg::BRK_OPEN;
              new_ent.stamp = s1_now_r;
            end
            pscb_pkg::BRK_CLOSED: begin
              new_ent.fcnt = f_inc;
              if (f_inc > CNT_W'(cfg.fail_limit)) begin
                new_ent.scnt  = '0;
                new_ent.st    = pscb_pkg::BRK_OPEN;
                new_ent.stamp = s1_now_r;
              end
            end
            default: begin
              // open: failure changes nothing
            end
          endcase
        end
        pscb_pkg::MODE_SUCCESS: begin
          if (cur_ent.st == pscb_pkg::BRK_HALF) begin
            new_ent.scnt = s_inc;
            if (s_inc > CNT_W'(cfg.success_limit)) begin
              new_ent.st   = pscb_pkg::BRK_CLOSED;
              new_ent.fcnt = '0;
              new_ent.scnt = '0;
            end
          end
        end
        default: begin
          // unused mode: no change
        end
      endcase
    end else begin
      res_allowed = (s1_ctl_r.mode == pscb_pkg::MODE_CHECK);
      // first failure creates the entry
      if (s1_ctl_r.mode == pscb_pkg::MODE_FAIL && s1_ctl_r.in_range) begin
        wr_need       = 1'b1;
        new_ent.valid = 1'b1;
        new_ent.st    = pscb_pkg::BRK_CLOSED;
        new_ent.fcnt  = CNT_W'(1);
        new_ent.scnt  = '0;
        new_ent.stamp = '0;
      end
    end

    res_after = res_known ? new_ent.st : pscb_pkg::BRK_CLOSED;
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == IDX_W'(SERVICE_COUNT - 1)) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_addr_r <= IDX_W'(clr_addr_r + 1'b1);
      end
    end
  end

  // Execute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Execute stage payload and same-service forwarding
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ctl_r  <= q_ctl;
      s1_idx_r  <= q_idx;
      s1_now_r  <= q_now;
      fwd_r     <= s1_done && wr_need && (s1_idx_r == q_idx);
      fwd_ent_r <= new_ent;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_allowed_r <= res_allowed;
      out_after_r   <= res_after;
      out_known_r   <= res_known;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_allowed       = out_allowed_r;
  assign out_breaker_after = out_after_r;
  assign out_known         = out_known_r;

endmodule
